### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

### hw/rtl/mexalu_pkg.sv
// ---------------------------------------------------------------------------
// Monomial exponent ALU package
// Widths, operation codes and beat types shared by the ALU modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mexalu_pkg;

   localparam int NUM_VARS  = 8;
   localparam int EXP_BITS  = 8;
   localparam int WORD_BITS = 64;
   localparam int MASK_BITS = 8;
   localparam int DEG_BITS  = 11;
   localparam int KIND_BITS = 3;

   typedef logic [KIND_BITS-1:0] kind_type;

   localparam kind_type KIND_MUL     = 3'd0;
   localparam kind_type KIND_DIV     = 3'd1;
   localparam kind_type KIND_DIVIDES = 3'd2;
   localparam kind_type KIND_ORDER   = 3'd3;
   localparam kind_type KIND_EQUAL   = 3'd4;
   localparam kind_type KIND_DISJ    = 3'd5;
   localparam kind_type KIND_WITHIN  = 3'd6;
   localparam kind_type KIND_IS_ONE  = 3'd7;

   typedef logic [EXP_BITS-1:0] exp_type;

   typedef struct packed {
      kind_type              kind;
      logic [WORD_BITS-1:0]  a_exponents;
      logic [WORD_BITS-1:0]  b_exponents;
      logic [MASK_BITS-1:0]  variable_mask;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  result_exponents;
      logic                  answer;
      logic                  overflow;
      logic [DEG_BITS-1:0]   total_degree;
   } rsp_type;

   // Per-lane findings handed from the lanes to the merge stage.
   typedef struct packed {
      exp_type a_val;
      exp_type b_val;
      exp_type sum;
      exp_type diff;
      logic    ovf;
      logic    lt;
      logic    eq;
      logic    a_nz;
      logic    b_nz;
      logic    allowed;
   } lane_type;

   typedef lane_type [NUM_VARS-1:0] lane_vec_type;

endpackage

`default_nettype wire

### hw/rtl/mexalu_lane.sv
// ---------------------------------------------------------------------------
// Monomial exponent ALU lane
// One exponent lane: saturating add, subtract and per-lane compare flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mexalu_lane (
   input  wire mexalu_pkg::exp_type  a_exp,
   input  wire mexalu_pkg::exp_type  b_exp,
   input  wire                       mask_bit,
   output mexalu_pkg::lane_type      lane_out
);

   logic [mexalu_pkg::EXP_BITS:0] wide_sum;

   assign wide_sum = {1'b0, a_exp} + {1'b0, b_exp};

   always_comb begin
      lane_out.a_val   = a_exp;
      lane_out.b_val   = b_exp;
      lane_out.ovf     = wide_sum[mexalu_pkg::EXP_BITS];
      // clamp at the lane maximum on carry out
      lane_out.sum     = wide_sum[mexalu_pkg::EXP_BITS]
                         ? '1 : wide_sum[mexalu_pkg::EXP_BITS-1:0];
      lane_out.diff    = a_exp - b_exp;
      lane_out.lt      = (a_exp < b_exp);
      lane_out.eq      = (a_exp == b_exp);
      lane_out.a_nz    = |a_exp;
      lane_out.b_nz    = |b_exp;
      lane_out.allowed = mask_bit;
   end

endmodule

`default_nettype wire

### hw/rtl/mexalu_merge.sv
// ---------------------------------------------------------------------------
// Monomial exponent ALU merge
// Combine lane findings into the result word, answer and total degree.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mexalu_merge (
   input  wire mexalu_pkg::kind_type      kind,
   input  wire mexalu_pkg::lane_vec_type  lanes,
   output mexalu_pkg::rsp_type            rsp
);

   logic                                 ge_all;
   logic                                 ovf_any;
   logic                                 eq_all;
   logic                                 disj_all;
   logic                                 within_all;
   logic                                 a_zero;
   logic                                 lex_lt;
   logic [mexalu_pkg::DEG_BITS-1:0]      deg_a;
   logic [mexalu_pkg::DEG_BITS-1:0]      deg_b;
   logic [mexalu_pkg::DEG_BITS-1:0]      deg_mul;
   logic [mexalu_pkg::DEG_BITS-1:0]      deg_div;
   logic [mexalu_pkg::WORD_BITS-1:0]     mul_word;
   logic [mexalu_pkg::WORD_BITS-1:0]     div_word;

   always_comb begin
      ge_all     = 1'b1;
      ovf_any    = 1'b0;
      eq_all     = 1'b1;
      disj_all   = 1'b1;
      within_all = 1'b1;
      a_zero     = 1'b1;
      lex_lt     = 1'b0;
      deg_a      = '0;
      deg_b      = '0;
      deg_mul    = '0;
      deg_div    = '0;
      mul_word   = '0;
      div_word   = '0;
      // walk from the top lane down so the lowest differing lane decides
      for (int i = mexalu_pkg::NUM_VARS - 1; i >= 0; i--) begin
         if (!lanes[i].eq) begin
            lex_lt = lanes[i].lt;
         end
         ge_all     = ge_all & ~lanes[i].lt;
         ovf_any    = ovf_any | lanes[i].ovf;
         eq_all     = eq_all & lanes[i].eq;
         disj_all   = disj_all & ~(lanes[i].a_nz & lanes[i].b_nz);
         within_all = within_all & (~lanes[i].a_nz | lanes[i].allowed);
         a_zero     = a_zero & ~lanes[i].a_nz;
         deg_a      = deg_a + mexalu_pkg::DEG_BITS'(lanes[i].a_val);
         deg_b      = deg_b + mexalu_pkg::DEG_BITS'(lanes[i].b_val);
         deg_mul    = deg_mul + mexalu_pkg::DEG_BITS'(lanes[i].sum);
         deg_div    = deg_div + mexalu_pkg::DEG_BITS'(lanes[i].diff);
         mul_word[i*mexalu_pkg::EXP_BITS +: mexalu_pkg::EXP_BITS] = lanes[i].sum;
         div_word[i*mexalu_pkg::EXP_BITS +: mexalu_pkg::EXP_BITS] = lanes[i].diff;
      end
   end

   always_comb begin
      rsp = '0;
      unique case (kind)
         mexalu_pkg::KIND_MUL: begin
            rsp.result_exponents = mul_word;
            rsp.answer           = 1'b1;
            rsp.overflow         = ovf_any;
            rsp.total_degree     = deg_mul;
         end
         mexalu_pkg::KIND_DIV: begin
            // drop the quotient when any lane would go negative
            rsp.answer = ge_all;
            if (ge_all) begin
               rsp.result_exponents = div_word;
               rsp.total_degree     = deg_div;
            end
         end
         mexalu_pkg::KIND_DIVIDES: rsp.answer = ge_all;
         mexalu_pkg::KIND_ORDER: begin
            rsp.answer = (deg_a < deg_b) || ((deg_a == deg_b) && lex_lt);
         end
         mexalu_pkg::KIND_EQUAL:  rsp.answer = eq_all;
         mexalu_pkg::KIND_DISJ:   rsp.answer = disj_all;
         mexalu_pkg::KIND_WITHIN: rsp.answer = within_all;
         mexalu_pkg::KIND_IS_ONE: rsp.answer = a_zero;
         default:                 rsp.answer = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/monomial_exponent_alu_unit.sv
// ---------------------------------------------------------------------------
// Monomial exponent ALU unit
// Pipeline: request beat goes into the lane stage register, then through merge into the response register.
// Throughput: 1 beat per cycle while rsp_ready is high; the two pipeline registers set the rate.
// Reset: synchronous, clears both stage valids; no data state to restore.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module monomial_exponent_alu_unit (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire mexalu_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output mexalu_pkg::rsp_type   rsp_data
);

   // Lane stage: NUM_VARS lanes work on one exponent each.
   mexalu_pkg::lane_vec_type  lanes_in;
   mexalu_pkg::lane_vec_type  lanes_ff;
   mexalu_pkg::kind_type      kind_ff;
   logic                      s1_valid_ff;
   logic                      s1_valid_in;

   // Merge stage feeds the response register.
   mexalu_pkg::rsp_type       rsp_in;
   mexalu_pkg::rsp_type       rsp_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   logic                      out_free;
   logic                      s1_adv;
   logic                      req_fire;

   genvar g;
   generate
      for (g = 0; g < mexalu_pkg::NUM_VARS; g++) begin : g_lane
         mexalu_lane u_lane (
            .a_exp    (req_data.a_exponents[g*mexalu_pkg::EXP_BITS +: mexalu_pkg::EXP_BITS]),
            .b_exp    (req_data.b_exponents[g*mexalu_pkg::EXP_BITS +: mexalu_pkg::EXP_BITS]),
            .mask_bit (req_data.variable_mask[g]),
            .lane_out (lanes_in[g])
         );
      end
   endgenerate

   mexalu_merge u_merge (
      .kind  (kind_ff),
      .lanes (lanes_ff),
      .rsp   (rsp_in)
   );

   // The response register is free when empty or when its beat leaves now.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: load on a taken beat, hold while stalled.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         lanes_ff <= lanes_in;
         kind_ff  <= req_data.kind;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A lane-stage beat that finds the output free must show up next cycle.
   `ASSERT_CLK(a_stage_advance, clock, reset, s1_adv |=> rsp_valid_ff)
   // A blocked lane-stage beat is held, never dropped.
   `ASSERT_CLK(a_stage_hold, clock, reset, (s1_valid_ff && !out_free) |=> s1_valid_ff)
   // Overflow comes only from multiply, whose answer is always set.
   `ASSERT_NEVER(a_ovf_answer, clock, reset, rsp_valid_ff && rsp_ff.overflow && !rsp_ff.answer)
   // A nonzero degree needs a nonzero result word.
   `ASSERT_NEVER(a_deg_word, clock, reset,
      rsp_valid_ff && (rsp_ff.total_degree != '0) && (rsp_ff.result_exponents == '0))

endmodule

`default_nettype wire
